// ===== src/tsbq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbq_pkg
// Shared types and constants for the touch slider and button qualifier.
// ----------------------------------------------------------------------------
package tsbq_pkg;

  localparam int COUNTER_WIDTH_DEF = 8;
  localparam int NUM_BUTTONS       = 5;
  localparam int NUM_ZONES         = 3;
  localparam int ZONE_DOWN         = 0;
  localparam int ZONE_MID          = 1;
  localparam int ZONE_UP           = 2;
  localparam int CFG_WIDTH         = 18;
  localparam int CALC_WIDTH        = 20;
  localparam int SHIFT_WIDTH       = 4;

  localparam logic signed [CFG_WIDTH-1:0] UPPER_BASE_RST     = 18'sd28000;
  localparam logic signed [CFG_WIDTH-1:0] MIDDLE_OFFSET_RST  = -18'sd1500;
  localparam logic signed [CFG_WIDTH-1:0] LOWER_OFFSET_RST   = -18'sd7500;
  localparam logic signed [CFG_WIDTH-1:0] PERCENT_OFFSET_RST = 18'sd32934;
  localparam logic [31:0]                 POOL_SEED          = 32'd961748927;
  localparam logic [6:0]                  PERCENT_MAX        = 7'd100;

  typedef enum logic [1:0] {
    REG_UPPER_BASE     = 2'd0,
    REG_MIDDLE_OFFSET  = 2'd1,
    REG_LOWER_OFFSET   = 2'd2,
    REG_PERCENT_OFFSET = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [CFG_WIDTH-1:0] upper_base;
    logic signed [CFG_WIDTH-1:0] middle_offset;
    logic signed [CFG_WIDTH-1:0] lower_offset;
    logic signed [CFG_WIDTH-1:0] percent_offset;
  } cfg_t;

  typedef struct packed {
    logic [15:0] outer_pad_sum;
    logic [15:0] inner_pad_sum;
    logic [4:0]  button_levels;
  } in_t;

  typedef struct packed {
    logic [7:0]  solo_count;
    logic [7:0]  up_count;
    logic [7:0]  left_count;
    logic [7:0]  right_count;
    logic [7:0]  down_count;
    logic [7:0]  touch_low_count;
    logic [7:0]  touch_mid_count;
    logic [7:0]  touch_high_count;
    logic [6:0]  touch_percent;
    logic [5:0]  release_mask;
    logic [31:0] entropy_value;
  } out_t;

endpackage

// ===== src/touch_slider_and_button_qualifier.sv =====
// ----------------------------------------------------------------------------
// touch_slider_and_button_qualifier
// Qualifies capacitive slider touches and button holds once per scan tick.
// ----------------------------------------------------------------------------
// Each request carries one scan tick: two pad sums and five button levels.
// The block takes one request per clock while out_ready keeps the result
// register draining, and returns one result per request. A request waits in
// the input register while the counter, zone and entropy update runs in a
// single pass into the result register, which also writes back the counter
// state. A new request can enter the input register as the one before it moves
// on. While a result waits for out_ready, the request behind it stays in the
// input register and in_ready stays low until the result leaves. The user must
// write the configuration registers through the cfg port only while no request
// is in flight; the block itself does not enforce this.
module touch_slider_and_button_qualifier #(
  parameter int COUNTER_WIDTH = tsbq_pkg::COUNTER_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsbq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tsbq_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [17:0]     cfg_data
);

  logic           s1_valid_r;
  tsbq_pkg::in_t  s1_data_r;
  logic           out_valid_r;
  tsbq_pkg::out_t out_data_r;
  tsbq_pkg::out_t out_data_nxt;
  logic           step;
  tsbq_pkg::cfg_t cfg;

  logic [31:0]      pool_next;
  logic [2:0][7:0]  zone_count;
  logic [6:0]       percent;
  logic             inactive;
  logic [4:0][7:0]  hold_count;
  logic [4:0]       released;

  assign step      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || step;
  assign cfg_ready = 1'b1;

  tsbq_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tsbq_entropy u_entropy (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .outer_pad_sum (s1_data_r.outer_pad_sum),
    .inner_pad_sum (s1_data_r.inner_pad_sum),
    .pool_next     (pool_next)
  );

  tsbq_touch #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_touch (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cfg           (cfg),
    .outer_pad_sum (s1_data_r.outer_pad_sum),
    .inner_pad_sum (s1_data_r.inner_pad_sum),
    .zone_count    (zone_count),
    .percent       (percent),
    .inactive      (inactive)
  );

  tsbq_buttons #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_buttons (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .button_levels (s1_data_r.button_levels),
    .hold_count    (hold_count),
    .released      (released)
  );

  always_comb begin
    out_data_nxt.solo_count       = hold_count[0];
    out_data_nxt.up_count         = hold_count[1];
    out_data_nxt.left_count       = hold_count[2];
    out_data_nxt.right_count      = hold_count[3];
    out_data_nxt.down_count       = hold_count[4];
    out_data_nxt.touch_low_count  = zone_count[tsbq_pkg::ZONE_DOWN];
    out_data_nxt.touch_mid_count  = zone_count[tsbq_pkg::ZONE_MID];
    out_data_nxt.touch_high_count = zone_count[tsbq_pkg::ZONE_UP];
    out_data_nxt.touch_percent    = percent;
    out_data_nxt.release_mask     = {inactive, released};
    out_data_nxt.entropy_value    = pool_next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/tsbq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tsbq_cfg_regs
// Holds the four threshold and offset registers written over the config port.
// ----------------------------------------------------------------------------
module tsbq_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [1:0]              wr_index,
  input  logic [17:0]             wr_data,
  output tsbq_pkg::cfg_t          cfg
);

  tsbq_pkg::cfg_t cfg_r;
  tsbq_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (tsbq_pkg::cfg_index_t'(wr_index))
        tsbq_pkg::REG_UPPER_BASE:     cfg_nxt.upper_base     = wr_data;
        tsbq_pkg::REG_MIDDLE_OFFSET:  cfg_nxt.middle_offset  = wr_data;
        tsbq_pkg::REG_LOWER_OFFSET:   cfg_nxt.lower_offset   = wr_data;
        tsbq_pkg::REG_PERCENT_OFFSET: cfg_nxt.percent_offset = wr_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_base     <= tsbq_pkg::UPPER_BASE_RST;
      cfg_r.middle_offset  <= tsbq_pkg::MIDDLE_OFFSET_RST;
      cfg_r.lower_offset   <= tsbq_pkg::LOWER_OFFSET_RST;
      cfg_r.percent_offset <= tsbq_pkg::PERCENT_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tsbq_entropy.sv =====
// ----------------------------------------------------------------------------
// tsbq_entropy
// Tick counter and entropy pool; mixes both pad sums into the pool per tick.
// ----------------------------------------------------------------------------
module tsbq_entropy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [15:0] outer_pad_sum,
  input  logic [15:0] inner_pad_sum,
  output logic [31:0] pool_next
);

  // Only the low four tick bits are used as the shift amount, so only they are kept.
  logic [tsbq_pkg::SHIFT_WIDTH-1:0] tick_r;
  logic [tsbq_pkg::SHIFT_WIDTH-1:0] tick_nxt;
  logic [31:0]                      pool_r;
  logic [31:0]                      pool_mid;
  logic [31:0]                      pool_nxt;

  always_comb begin
    tick_nxt = tick_r + 1'b1;
    pool_mid = {16'b0, outer_pad_sum} ^ (pool_r << tick_nxt);
    pool_nxt = {16'b0, inner_pad_sum} ^ (pool_mid << tick_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      pool_r <= tsbq_pkg::POOL_SEED;
    end else if (step) begin
      tick_r <= tick_nxt;
      pool_r <= pool_nxt;
    end
  end

  assign pool_next = pool_nxt;

endmodule

// ===== src/tsbq_touch.sv =====
// ----------------------------------------------------------------------------
// tsbq_touch
// Touch detection, zone counters and the clamped touch percent estimate.
// ----------------------------------------------------------------------------
module tsbq_touch #(
  parameter int COUNTER_WIDTH = tsbq_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  tsbq_pkg::cfg_t        cfg,
  input  logic [15:0]           outer_pad_sum,
  input  logic [15:0]           inner_pad_sum,
  output logic [2:0][7:0]       zone_count,
  output logic [6:0]            percent,
  output logic                  inactive
);

  localparam int CW = tsbq_pkg::CALC_WIDTH;
  localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [COUNTER_WIDTH-1:0] zone_r   [tsbq_pkg::NUM_ZONES];
  logic [COUNTER_WIDTH-1:0] zone_nxt [tsbq_pkg::NUM_ZONES];
  logic [6:0]               pct_r;
  logic [6:0]               pct_nxt;

  logic signed [CW-1:0] outer_s;
  logic signed [CW-1:0] inner_s;
  logic signed [CW-1:0] two_outer;
  logic signed [CW-1:0] three_outer;
  logic signed [CW-1:0] bound;
  logic signed [CW-1:0] y2;
  logic signed [CW-1:0] y3;
  logic signed [CW-1:0] pct_raw;
  logic                 active;
  logic [7:0]           pct_byte;
  logic [2:0]           bump;
  logic [COUNTER_WIDTH+7:0] zone_ext [tsbq_pkg::NUM_ZONES];

  always_comb begin
    outer_s     = signed'({4'b0, outer_pad_sum});
    inner_s     = signed'({4'b0, inner_pad_sum});
    two_outer   = outer_s <<< 1;
    three_outer = two_outer + outer_s;
    bound   = signed'({{2{cfg.upper_base[17]}}, cfg.upper_base}) - two_outer;
    y2      = signed'({{2{cfg.middle_offset[17]}}, cfg.middle_offset}) + two_outer;
    y3      = signed'({{2{cfg.lower_offset[17]}}, cfg.lower_offset}) + two_outer;
    pct_raw = inner_s - three_outer
              + signed'({{2{cfg.percent_offset[17]}}, cfg.percent_offset});
    active  = inner_s < bound;

    // The second byte of the sum is read as a signed value before clamping.
    pct_byte = pct_raw[15:8];

    // An inner sum exactly on a zone boundary bumps no zone.
    bump[tsbq_pkg::ZONE_DOWN] = inner_s < y3;
    bump[tsbq_pkg::ZONE_MID]  = (inner_s < y2) && (inner_s > y3);
    bump[tsbq_pkg::ZONE_UP]   = inner_s > y2;

    for (int k = 0; k < tsbq_pkg::NUM_ZONES; k++) begin
      if (!active) begin
        zone_nxt[k] = '0;
      end else if (bump[k] && (zone_r[k] != COUNT_MAX)) begin
        zone_nxt[k] = zone_r[k] + 1'b1;
      end else begin
        zone_nxt[k] = zone_r[k];
      end
      zone_ext[k]   = {8'b0, zone_nxt[k]};
      zone_count[k] = zone_ext[k][7:0];
    end

    if (!active || pct_byte[7]) begin
      pct_nxt = '0;
    end else if (pct_byte[6:0] > tsbq_pkg::PERCENT_MAX) begin
      pct_nxt = tsbq_pkg::PERCENT_MAX;
    end else begin
      pct_nxt = pct_byte[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tsbq_pkg::NUM_ZONES; k++) begin
        zone_r[k] <= '0;
      end
      pct_r <= '0;
    end else if (step) begin
      for (int k = 0; k < tsbq_pkg::NUM_ZONES; k++) begin
        zone_r[k] <= zone_nxt[k];
      end
      pct_r <= pct_nxt;
    end
  end

  // The percent is recomputed from scratch each tick; the register keeps the
  // last value as block state.
  assign percent  = step ? pct_nxt : pct_r;
  assign inactive = !active;

endmodule

// ===== src/tsbq_buttons.sv =====
// ----------------------------------------------------------------------------
// tsbq_buttons
// Saturating hold counters for the five active-low buttons.
// ----------------------------------------------------------------------------
module tsbq_buttons #(
  parameter int COUNTER_WIDTH = tsbq_pkg::COUNTER_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [4:0]      button_levels,
  output logic [4:0][7:0] hold_count,
  output logic [4:0]      released
);

  localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [COUNTER_WIDTH-1:0]   btn_r   [tsbq_pkg::NUM_BUTTONS];
  logic [COUNTER_WIDTH-1:0]   btn_nxt [tsbq_pkg::NUM_BUTTONS];
  logic [COUNTER_WIDTH+7:0]   btn_ext [tsbq_pkg::NUM_BUTTONS];

  always_comb begin
    for (int k = 0; k < tsbq_pkg::NUM_BUTTONS; k++) begin
      if (button_levels[k]) begin
        btn_nxt[k] = '0;
      end else if (btn_r[k] != COUNT_MAX) begin
        btn_nxt[k] = btn_r[k] + 1'b1;
      end else begin
        btn_nxt[k] = btn_r[k];
      end
      btn_ext[k]    = {8'b0, btn_nxt[k]};
      hold_count[k] = btn_ext[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tsbq_pkg::NUM_BUTTONS; k++) begin
        btn_r[k] <= '0;
      end
    end else if (step) begin
      for (int k = 0; k < tsbq_pkg::NUM_BUTTONS; k++) begin
        btn_r[k] <= btn_nxt[k];
      end
    end
  end

  // A high pin level means the button is up.
  assign released = button_levels;

endmodule
